// File: rtl/line_plane_intersection_top_defines.svh
// Assertion helpers shared by the RTL; both sample on aclk and hold off during reset.
`ifndef LINE_PLANE_INTERSECTION_TOP_DEFINES_SVH
`define LINE_PLANE_INTERSECTION_TOP_DEFINES_SVH

// Same-cycle implication.
`define LPI_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define LPI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/lpi_pkg.sv
package lpi_pkg;

    localparam int COORD_WIDTH = 21;
    localparam int FRAC_BITS   = 10;
    localparam int FIELD_W     = 63;
    localparam int TOL_W       = 20;
    localparam logic [TOL_W-1:0] TOL_RESET = 20'd1;

    // k is Q.16 and saturates at 2^40, so 41 quotient bits are enough
    localparam int K_FRAC = 16;
    localparam int Q_W    = 41;
    localparam int Q_LO_W = 21;
    localparam int Q_HI_W = Q_W - Q_LO_W;
    localparam logic [Q_W-1:0] K_MAX = 41'h100_0000_0000;

    typedef enum logic [1:0] {
        ST_PARALLEL = 2'd0,
        ST_ONE      = 2'd1,
        ST_PLANE    = 2'd2,
        ST_OUTSIDE  = 2'd3
    } status_t;

endpackage

// File: rtl/lpi_front.sv
module lpi_front #(
    parameter int CW = lpi_pkg::COORD_WIDTH,
    parameter int FB = lpi_pkg::FRAC_BITS,
    parameter int DW = 2*CW + 3,
    parameter int SW = 6*CW + 9
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [lpi_pkg::TOL_W-1:0]   tol,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [3*CW-1:0]             in_pp,
    input  logic [3*CW-1:0]             in_pn,
    input  logic [3*CW-1:0]             in_ls,
    input  logic [3*CW-1:0]             in_le,
    input  logic [1:0]                  in_flags,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [DW-1:0]               out_p,
    output logic [DW-1:0]               out_d,
    output logic [lpi_pkg::Q_W-1:0]     out_nlo,
    output logic [SW-1:0]               out_side
);

    localparam int PW  = 2*CW + 1;
    localparam int NW  = DW + lpi_pkg::K_FRAC + 1;
    localparam int P0W = NW - lpi_pkg::Q_W;
    localparam int EPW = lpi_pkg::TOL_W + FB;
    localparam int EW  = (DW > EPW) ? DW : EPW;

    logic [3:0] v_reg;
    logic [3:0] adv;

    always_comb begin
        adv[3] = !v_reg[3] || out_ready;
        for (int k = 2; k >= 0; k--) begin
            adv[k] = !v_reg[k] || adv[k+1];
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = v_reg[3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (adv[0]) v_reg[0] <= in_valid;
            for (int k = 1; k < 4; k++) begin
                if (adv[k]) v_reg[k] <= v_reg[k-1];
            end
        end
    end

    // stage 1: differences
    logic [CW-1:0]        a_c [3];
    logic [CW-1:0]        x_c [3];
    logic [CW-1:0]        y_c [3];
    logic signed [CW:0]   ax_next [3];
    logic signed [CW:0]   w_next [3];
    logic signed [CW:0]   ax_reg [3];
    logic signed [CW:0]   w1_reg [3];
    logic signed [CW-1:0] n1_reg [3];
    logic [CW-1:0]        x1_reg [3];
    logic [1:0]           fl1_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            a_c[i]     = in_pp[i*CW +: CW];
            x_c[i]     = in_ls[i*CW +: CW];
            y_c[i]     = in_le[i*CW +: CW];
            ax_next[i] = {a_c[i][CW-1], a_c[i]} - {x_c[i][CW-1], x_c[i]};
            w_next[i]  = {y_c[i][CW-1], y_c[i]} - {x_c[i][CW-1], x_c[i]};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            for (int i = 0; i < 3; i++) begin
                ax_reg[i] <= ax_next[i];
                w1_reg[i] <= w_next[i];
                n1_reg[i] <= in_pn[i*CW +: CW];
                x1_reg[i] <= x_c[i];
            end
            fl1_reg <= in_flags;
        end
    end

    // stage 2: products
    logic signed [PW-1:0] pd_next [3];
    logic signed [PW-1:0] pe_next [3];
    logic signed [PW-1:0] pd_reg [3];
    logic signed [PW-1:0] pe_reg [3];
    logic signed [CW:0]   w2_reg [3];
    logic [CW-1:0]        x2_reg [3];
    logic [1:0]           fl2_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pd_next[i] = n1_reg[i] * ax_reg[i];
            pe_next[i] = n1_reg[i] * w1_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            for (int i = 0; i < 3; i++) begin
                pd_reg[i] <= pd_next[i];
                pe_reg[i] <= pe_next[i];
                w2_reg[i] <= w1_reg[i];
                x2_reg[i] <= x1_reg[i];
            end
            fl2_reg <= fl1_reg;
        end
    end

    // stage 3: dot products
    logic signed [DW-1:0] d_reg;
    logic signed [DW-1:0] e_reg;
    logic signed [CW:0]   w3_reg [3];
    logic [CW-1:0]        x3_reg [3];
    logic [1:0]           fl3_reg;

    always_ff @(posedge aclk) begin
        if (adv[2]) begin
            d_reg <= DW'(pd_reg[0]) + DW'(pd_reg[1]) + DW'(pd_reg[2]);
            e_reg <= DW'(pe_reg[0]) + DW'(pe_reg[1]) + DW'(pe_reg[2]);
            for (int i = 0; i < 3; i++) begin
                w3_reg[i] <= w2_reg[i];
                x3_reg[i] <= x2_reg[i];
            end
            fl3_reg <= fl2_reg;
        end
    end

    // stage 4: classify and set up the division
    logic [DW-1:0]          ad;
    logic [DW-1:0]          ae;
    logic [EPW-1:0]         eps2;
    logic                   big;
    logic                   inplane;
    logic [NW-1:0]          num;
    logic [P0W-1:0]         p0;
    logic                   ovf;
    lpi_pkg::status_t       cls;
    logic [SW-1:0]          side_next;
    logic [DW-1:0]          p_reg;
    logic [DW-1:0]          dv_reg;
    logic [lpi_pkg::Q_W-1:0] nlo_reg;
    logic [SW-1:0]          side_reg;

    always_comb begin
        ad      = d_reg[DW-1] ? DW'(-d_reg) : DW'(d_reg);
        ae      = e_reg[DW-1] ? DW'(-e_reg) : DW'(e_reg);
        eps2    = {tol, FB'(0)};
        big     = EW'(ae) > EW'(eps2);
        inplane = EW'(ad) <= EW'(eps2);
        num     = (NW'(ad) << lpi_pkg::K_FRAC) + NW'(ae >> 1);
        p0      = num[NW-1:lpi_pkg::Q_W];
        ovf     = DW'(p0) >= ae;
        if (big) begin
            cls = lpi_pkg::ST_ONE;
        end else if (inplane) begin
            cls = lpi_pkg::ST_PLANE;
        end else begin
            cls = lpi_pkg::ST_PARALLEL;
        end
        side_next = '0;
        for (int i = 0; i < 3; i++) begin
            side_next[i*CW +: CW]              = x3_reg[i];
            side_next[3*CW + i*(CW+1) +: CW+1] = w3_reg[i];
        end
        side_next[SW-1 -: 6] = {ovf, d_reg[DW-1] ^ e_reg[DW-1], cls, fl3_reg};
    end

    always_ff @(posedge aclk) begin
        if (adv[3]) begin
            p_reg    <= DW'(p0);
            dv_reg   <= ae;
            nlo_reg  <= num[lpi_pkg::Q_W-1:0];
            side_reg <= side_next;
        end
    end

    assign out_p    = p_reg;
    assign out_d    = dv_reg;
    assign out_nlo  = nlo_reg;
    assign out_side = side_reg;

endmodule

// File: rtl/lpi_div_cell.sv
module lpi_div_cell #(
    parameter int DW  = 2*lpi_pkg::COORD_WIDTH + 3,
    parameter int SW  = 6*lpi_pkg::COORD_WIDTH + 9,
    parameter int BIT = 0
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [DW-1:0]           in_p,
    input  logic [DW-1:0]           in_d,
    input  logic [lpi_pkg::Q_W-1:0] in_nlo,
    input  logic [lpi_pkg::Q_W-1:0] in_q,
    input  logic [SW-1:0]           in_side,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [DW-1:0]           out_p,
    output logic [DW-1:0]           out_d,
    output logic [lpi_pkg::Q_W-1:0] out_nlo,
    output logic [lpi_pkg::Q_W-1:0] out_q,
    output logic [SW-1:0]           out_side
);

    logic                    v_reg;
    logic [DW:0]             t;
    logic [DW:0]             diff;
    logic                    ge;
    logic [DW-1:0]           p_next;
    logic [lpi_pkg::Q_W-1:0] q_next;
    logic [DW-1:0]           p_reg;
    logic [DW-1:0]           d_reg;
    logic [lpi_pkg::Q_W-1:0] nlo_reg;
    logic [lpi_pkg::Q_W-1:0] q_reg;
    logic [SW-1:0]           side_reg;

    assign in_ready = !v_reg || out_ready;

    // shift in the next numerator bit, subtract where the divisor fits
    always_comb begin
        t      = {in_p, in_nlo[BIT]};
        diff   = t - {1'b0, in_d};
        ge     = t >= {1'b0, in_d};
        p_next = ge ? diff[DW-1:0] : t[DW-1:0];
        q_next = in_q;
        q_next[BIT] = ge;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (in_ready) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            p_reg    <= p_next;
            d_reg    <= in_d;
            nlo_reg  <= in_nlo;
            q_reg    <= q_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = v_reg;
    assign out_p     = p_reg;
    assign out_d     = d_reg;
    assign out_nlo   = nlo_reg;
    assign out_q     = q_reg;
    assign out_side  = side_reg;

endmodule

// File: rtl/lpi_back.sv
module lpi_back #(
    parameter int CW = lpi_pkg::COORD_WIDTH,
    parameter int FB = lpi_pkg::FRAC_BITS,
    parameter int SW = 6*CW + 9
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [lpi_pkg::TOL_W-1:0] tol,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [lpi_pkg::Q_W-1:0]   in_q,
    input  logic [SW-1:0]             in_side,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [1:0]                out_status,
    output logic [CW-1:0]             out_x,
    output logic [CW-1:0]             out_y,
    output logic [CW-1:0]             out_z
);

    localparam int FO   = 6*CW + 3;
    localparam int TKW  = lpi_pkg::TOL_W + lpi_pkg::K_FRAC - FB;
    localparam int CKW  = lpi_pkg::Q_W + 1;
    localparam int LOW  = CW + 1 + lpi_pkg::Q_LO_W;
    localparam int HIW  = CW + 1 + lpi_pkg::Q_HI_W;
    localparam int MW   = CW + 1 + lpi_pkg::Q_W;
    localparam int RW   = MW + 1 - lpi_pkg::K_FRAC;
    localparam int SUMW = RW + 2;
    localparam logic signed [SUMW-1:0] C_HI = SUMW'((1 << (CW-1)) - 1);
    localparam logic signed [SUMW-1:0] C_LO = -C_HI - SUMW'(1);

    logic [3:0] v_reg;
    logic [3:0] adv;

    always_comb begin
        adv[3] = !v_reg[3] || out_ready;
        for (int k = 2; k >= 0; k--) begin
            adv[k] = !v_reg[k] || adv[k+1];
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = v_reg[3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (adv[0]) v_reg[0] <= in_valid;
            for (int k = 1; k < 4; k++) begin
                if (adv[k]) v_reg[k] <= v_reg[k-1];
            end
        end
    end

    // stage 1: saturate k, bound tests
    logic [lpi_pkg::Q_W-1:0] q_sat;
    logic                    kneg;
    logic [TKW-1:0]          tolk;
    logic [CKW-1:0]          qk;
    logic [CKW-1:0]          tk;
    logic [CKW-1:0]          lim;
    logic                    oos;
    lpi_pkg::status_t        cls;
    lpi_pkg::status_t        st_next;
    logic [lpi_pkg::Q_W-1:0] q1_reg;
    logic                    kneg1_reg;
    lpi_pkg::status_t        st1_reg;
    logic signed [CW-1:0]    x1_reg [3];
    logic [CW:0]             w1_reg [3];

    always_comb begin
        q_sat = (in_side[SW-1] || (in_q > lpi_pkg::K_MAX)) ? lpi_pkg::K_MAX : in_q;
        kneg  = in_side[FO+4] && (q_sat != '0);
        tolk  = TKW'(tol) << (lpi_pkg::K_FRAC - FB);
        qk    = CKW'(q_sat);
        tk    = CKW'(tolk);
        lim   = tk + CKW'(1 << lpi_pkg::K_FRAC);
        oos   = (in_side[FO] && kneg && (qk > tk)) || (in_side[FO+1] && !kneg && (qk > lim));
        cls   = lpi_pkg::status_t'(in_side[FO+2 +: 2]);
        st_next = (cls == lpi_pkg::ST_ONE && oos) ? lpi_pkg::ST_OUTSIDE : cls;
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            q1_reg    <= q_sat;
            kneg1_reg <= kneg;
            st1_reg   <= st_next;
            for (int i = 0; i < 3; i++) begin
                x1_reg[i] <= in_side[i*CW +: CW];
                w1_reg[i] <= in_side[3*CW + i*(CW+1) +: CW+1];
            end
        end
    end

    // stage 2: |w| * k as two partial products
    logic [CW:0]          mw [3];
    logic [LOW-1:0]       lo_reg [3];
    logic [HIW-1:0]       hi_reg [3];
    logic [2:0]           neg2_reg;
    lpi_pkg::status_t     st2_reg;
    logic signed [CW-1:0] x2_reg [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mw[i] = w1_reg[i][CW] ? (CW+1)'(-w1_reg[i]) : w1_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            for (int i = 0; i < 3; i++) begin
                lo_reg[i]   <= LOW'(mw[i]) * LOW'(q1_reg[lpi_pkg::Q_LO_W-1:0]);
                hi_reg[i]   <= HIW'(mw[i]) * HIW'(q1_reg[lpi_pkg::Q_W-1:lpi_pkg::Q_LO_W]);
                neg2_reg[i] <= w1_reg[i][CW] ^ kneg1_reg;
                x2_reg[i]   <= x1_reg[i];
            end
            st2_reg <= st1_reg;
        end
    end

    // stage 3: join and round to the coordinate scale
    logic [MW-1:0]        m [3];
    logic [MW:0]          mr [3];
    logic [RW-1:0]        r3_reg [3];
    logic [2:0]           neg3_reg;
    lpi_pkg::status_t     st3_reg;
    logic signed [CW-1:0] x3_reg [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            m[i]  = MW'(lo_reg[i]) + (MW'(hi_reg[i]) << lpi_pkg::Q_LO_W);
            mr[i] = (MW+1)'(m[i]) + (MW+1)'(1 << (lpi_pkg::K_FRAC-1));
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[2]) begin
            for (int i = 0; i < 3; i++) begin
                r3_reg[i] <= mr[i][MW:lpi_pkg::K_FRAC];
                x3_reg[i] <= x2_reg[i];
            end
            neg3_reg <= neg2_reg;
            st3_reg  <= st2_reg;
        end
    end

    // stage 4: add to the start point, saturate, pick by status
    logic signed [SUMW-1:0] mag_s [3];
    logic signed [SUMW-1:0] sum [3];
    logic [CW-1:0]          sat [3];
    logic [CW-1:0]          res [3];
    logic [1:0]             st_reg;
    logic [CW-1:0]          res_reg [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mag_s[i] = signed'(SUMW'(r3_reg[i]));
            sum[i]   = SUMW'(x3_reg[i]) + (neg3_reg[i] ? -mag_s[i] : mag_s[i]);
            if (sum[i] > C_HI) begin
                sat[i] = CW'(C_HI);
            end else if (sum[i] < C_LO) begin
                sat[i] = CW'(C_LO);
            end else begin
                sat[i] = sum[i][CW-1:0];
            end
            unique case (st3_reg)
                lpi_pkg::ST_ONE, lpi_pkg::ST_OUTSIDE: res[i] = sat[i];
                lpi_pkg::ST_PLANE:                    res[i] = x3_reg[i];
                lpi_pkg::ST_PARALLEL:                 res[i] = '0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[3]) begin
            st_reg <= st3_reg;
            for (int i = 0; i < 3; i++) begin
                res_reg[i] <= res[i];
            end
        end
    end

    assign out_status = st_reg;
    assign out_x      = res_reg[0];
    assign out_y      = res_reg[1];
    assign out_z      = res_reg[2];

endmodule

// File: rtl/line_plane_intersection_top.sv
// Line / plane crossing point.
// s_ channel: one query per item. tdata carries plane point, plane normal, line start and
// line end (63 bits each, three signed Q.FRAC_BITS coordinates, x lowest); tuser carries the
// start and end bound flags. m_ channel: tuser is the status (parallel, one point, line in
// plane, outside bounds), tdata the crossing point x, y, z.
// cfg_ channel writes the tolerance; it is always ready; the user must write it only
// while idle, which the block itself does not enforce. Four set-up stages form d and e,
// then 41 cells of a restoring divider (one quotient bit of k per cell) and four stages of
// scaling, rounding and saturation, the last being the output register. Throughput is one
// item per cycle while m_tready does not stall. Every stage has its own valid bit and moves
// on whenever the stage after it is empty or moving, so a stall at m_tready fills empty
// stages first and s_tready falls only when all 49 stages hold an item.
// Reset empties every stage and sets the tolerance to 1 LSB.
module line_plane_intersection_top #(
    parameter int COORD_WIDTH = lpi_pkg::COORD_WIDTH,
    parameter int FRAC_BITS   = lpi_pkg::FRAC_BITS
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // plane_point, plane_normal, line_start, line_end, zero pad
    input  logic [255:0]                           s_tdata,
    // start_bounded, end_bounded
    input  logic [1:0]                             s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // cross_x, cross_y, cross_z, zero pad
    output logic [((3*COORD_WIDTH+7)/8)*8-1:0]     m_tdata,
    // status
    output logic [1:0]                             m_tuser,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [lpi_pkg::TOL_W-1:0]              cfg_data
);

    `include "line_plane_intersection_top_defines.svh"

    localparam int CW   = COORD_WIDTH;
    localparam int DW   = 2*CW + 3;
    localparam int SW   = 6*CW + 9;
    localparam int QW   = lpi_pkg::Q_W;
    localparam int FW   = lpi_pkg::FIELD_W;
    localparam int OUTW = ((3*CW+7)/8)*8;

    logic [lpi_pkg::TOL_W-1:0] tol_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= lpi_pkg::TOL_RESET;
        end else if (cfg_valid) begin
            tol_reg <= cfg_data;
        end
    end

    logic          c_valid [QW+1];
    logic          c_ready [QW+1];
    logic [DW-1:0] c_p     [QW+1];
    logic [DW-1:0] c_d     [QW+1];
    logic [QW-1:0] c_nlo   [QW+1];
    logic [QW-1:0] c_q     [QW+1];
    logic [SW-1:0] c_side  [QW+1];

    assign c_q[0] = '0;

    lpi_front #(
        .CW (CW),
        .FB (FRAC_BITS),
        .DW (DW),
        .SW (SW)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .tol       (tol_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_pp     (s_tdata[0 +: 3*CW]),
        .in_pn     (s_tdata[FW +: 3*CW]),
        .in_ls     (s_tdata[2*FW +: 3*CW]),
        .in_le     (s_tdata[3*FW +: 3*CW]),
        .in_flags  (s_tuser),
        .out_valid (c_valid[0]),
        .out_ready (c_ready[0]),
        .out_p     (c_p[0]),
        .out_d     (c_d[0]),
        .out_nlo   (c_nlo[0]),
        .out_side  (c_side[0])
    );

    // quotient bits from the top down, one per cell
    for (genvar j = 0; j < QW; j++) begin : g_cell
        lpi_div_cell #(
            .DW  (DW),
            .SW  (SW),
            .BIT (QW-1-j)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (c_valid[j]),
            .in_ready  (c_ready[j]),
            .in_p      (c_p[j]),
            .in_d      (c_d[j]),
            .in_nlo    (c_nlo[j]),
            .in_q      (c_q[j]),
            .in_side   (c_side[j]),
            .out_valid (c_valid[j+1]),
            .out_ready (c_ready[j+1]),
            .out_p     (c_p[j+1]),
            .out_d     (c_d[j+1]),
            .out_nlo   (c_nlo[j+1]),
            .out_q     (c_q[j+1]),
            .out_side  (c_side[j+1])
        );
    end

    logic [CW-1:0] cx;
    logic [CW-1:0] cy;
    logic [CW-1:0] cz;

    lpi_back #(
        .CW (CW),
        .FB (FRAC_BITS),
        .SW (SW)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .tol        (tol_reg),
        .in_valid   (c_valid[QW]),
        .in_ready   (c_ready[QW]),
        .in_q       (c_q[QW]),
        .in_side    (c_side[QW]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (m_tuser),
        .out_x      (cx),
        .out_y      (cy),
        .out_z      (cz)
    );

    assign m_tdata = OUTW'({cz, cy, cx});

    // overflow flag sits at the top of the side word
    `LPI_ASSERT_NOW(a_par_zero, m_tvalid && (m_tuser == 2'(lpi_pkg::ST_PARALLEL)), m_tdata == '0, "parallel result carries a nonzero point")
    `LPI_ASSERT_NOW(a_rem_entry, c_valid[0] && !c_side[0][SW-1], c_p[0] < c_d[0], "divider entry remainder not below divisor")
    `LPI_ASSERT_NOW(a_rem_exit, c_valid[QW] && !c_side[QW][SW-1], c_p[QW] < c_d[QW], "divider exit remainder not below divisor")
    `LPI_ASSERT_NEXT(a_cfg_take, cfg_valid, tol_reg == $past(cfg_data), "tolerance write lost")

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int CW      = lpi_pkg::COORD_WIDTH;
    localparam int FB      = lpi_pkg::FRAC_BITS;
    localparam int FW      = lpi_pkg::FIELD_W;
    localparam int TW      = lpi_pkg::TOL_W;
    localparam int MDATA_W = ((3*CW+7)/8)*8;
    localparam int LAT     = 49;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [FW-1:0] plane_point;
        logic [FW-1:0] plane_normal;
        logic [FW-1:0] line_start;
        logic [FW-1:0] line_end;
        logic          start_bounded;
        logic          end_bounded;
    } query_t;

    typedef struct packed {
        lpi_pkg::status_t status;
        logic [CW-1:0]    cx;
        logic [CW-1:0]    cy;
        logic [CW-1:0]    cz;
    } crossing_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [255:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [MDATA_W-1:0] m_tdata;
    logic [1:0] m_tuser;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [TW-1:0] cfg_data = '0;

    line_plane_intersection_top i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    logic [TW-1:0] tol_model = lpi_pkg::TOL_RESET;
    crossing_t     pending_crossings[$];
    int            errors = 0;
    longint        cycles = 0;
    bit            quiet = 1'b0;
    bit            hold_long = 1'b0;
    int unsigned   idle_cnt = 0;

    function automatic longint coord(logic [FW-1:0] w, int i);
        logic signed [CW-1:0] c;
        c = w[i*CW +: CW];
        return longint'(c);
    endfunction

    function automatic longint magn(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint clamp(longint v);
        longint hi, lo;
        hi = (longint'(1) <<< (CW-1)) - 1;
        lo = -(longint'(1) <<< (CW-1));
        return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    // d, e stay below 2^43: magnitudes fit in 64-bit unsigned, d<<16 fits in 59 bits
    function automatic crossing_t predict_crossing(query_t q);
        crossing_t r;
        longint x[3], w[3], res[3];
        longint d, e, k, tolk;
        logic [63:0] eps2, ad, ae;
        logic [127:0] num, quo, m, t;
        bit kneg, neg;
        d = 0;
        e = 0;
        eps2 = 64'(tol_model) << FB;
        for (int i = 0; i < 3; i++) begin
            x[i] = coord(q.line_start, i);
            w[i] = coord(q.line_end, i) - x[i];
            d += coord(q.plane_normal, i) * (coord(q.plane_point, i) - x[i]);
            e += coord(q.plane_normal, i) * w[i];
        end
        ad = magn(d);
        ae = magn(e);
        if (ae > eps2) begin
            num = (128'(ad) << lpi_pkg::K_FRAC) + 128'(ae >> 1);
            quo = num / 128'(ae);
            kneg = ((d < 0) != (e < 0)) && quo != 0;
            if (quo > 128'(lpi_pkg::K_MAX)) quo = 128'(lpi_pkg::K_MAX);
            k = kneg ? -longint'(quo) : longint'(quo);
            for (int i = 0; i < 3; i++) begin
                m = 128'(magn(w[i])) * quo;
                t = (m + (128'(1) << (lpi_pkg::K_FRAC-1))) >> lpi_pkg::K_FRAC;
                neg = ((w[i] < 0) != kneg) && t != 0;
                res[i] = clamp(x[i] + (neg ? -longint'(t) : longint'(t)));
            end
            tolk = longint'(tol_model) <<< (lpi_pkg::K_FRAC - FB);
            if ((q.start_bounded && k < -tolk) ||
                (q.end_bounded && k > (longint'(1) <<< lpi_pkg::K_FRAC) + tolk))
                r.status = lpi_pkg::ST_OUTSIDE;
            else
                r.status = lpi_pkg::ST_ONE;
        end else if (ad <= eps2) begin
            for (int i = 0; i < 3; i++) res[i] = x[i];
            r.status = lpi_pkg::ST_PLANE;
        end else begin
            for (int i = 0; i < 3; i++) res[i] = 0;
            r.status = lpi_pkg::ST_PARALLEL;
        end
        r.cx = res[0][CW-1:0];
        r.cy = res[1][CW-1:0];
        r.cz = res[2][CW-1:0];
        return r;
    endfunction

    function automatic logic [FW-1:0] vec3(longint vx, longint vy, longint vz);
        return {vz[CW-1:0], vy[CW-1:0], vx[CW-1:0]};
    endfunction

    // mostly small coordinates so crossings land in range, some full range
    function automatic logic [FW-1:0] rand_vec(int mode);
        logic [FW-1:0] v;
        if (mode == 0)
            return FW'({$urandom, $urandom});
        for (int i = 0; i < 3; i++)
            v[i*CW +: CW] = CW'($signed($urandom_range(8192, 0)) - 4096);
        return v;
    endfunction

    function automatic query_t rand_query();
        query_t q;
        int mode, shape;
        mode = ($urandom_range(9, 0) == 0) ? 0 : 1;
        shape = $urandom_range(9, 0);
        q.plane_point  = rand_vec(mode);
        q.plane_normal = rand_vec(mode);
        q.line_start   = rand_vec(mode);
        q.line_end     = rand_vec(mode);
        if (shape == 0) begin
            // line parallel to the z=c plane
            q.plane_normal = vec3(0, 0, 1024);
            q.line_end[2*CW +: CW] = q.line_start[2*CW +: CW];
        end else if (shape == 1) begin
            q.plane_normal = vec3(0, 0, 1024);
            q.line_end[2*CW +: CW] = q.line_start[2*CW +: CW];
            q.plane_point[2*CW +: CW] = q.line_start[2*CW +: CW];
        end
        q.start_bounded = 1'($urandom);
        q.end_bounded   = 1'($urandom);
        return q;
    endfunction

    task automatic send_query(query_t q);
        s_tdata  <= {4'b0, q.line_end, q.line_start, q.plane_normal, q.plane_point};
        s_tuser  <= {q.end_bounded, q.start_bounded};
        s_tvalid <= 1'b1;
        pending_crossings.push_back(predict_crossing(q));
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (!quiet && $urandom_range(3, 0) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(10, 1)) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_crossings.size() != 0) @(posedge aclk);
        repeat (LAT + 4) @(posedge aclk);
    endtask

    task automatic write_tolerance(logic [TW-1:0] v);
        drain();
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        tol_model = v;
    endtask

    // receiver: random idle bursts, or a long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            idle_cnt <= 0;
        end else if (hold_long) begin
            m_tready <= 1'b0;
        end else if (quiet) begin
            m_tready <= 1'b1;
        end else if (idle_cnt != 0) begin
            m_tready <= 1'b0;
            idle_cnt <= idle_cnt - 1;
        end else if ($urandom_range(4, 0) == 0) begin
            m_tready <= 1'b0;
            idle_cnt <= $urandom_range(9, 0);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        crossing_t exp_c, got;
        cycles <= cycles + 1;
        if (aresetn && m_tvalid && m_tready) begin
            got.status = lpi_pkg::status_t'(m_tuser);
            got.cx = m_tdata[0 +: CW];
            got.cy = m_tdata[CW +: CW];
            got.cz = m_tdata[2*CW +: CW];
            if (pending_crossings.size() == 0) begin
                $display("%0t: unexpected item status=%0d", $time, got.status);
                errors++;
            end else begin
                exp_c = pending_crossings.pop_front();
                if (got.status !== exp_c.status) begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             exp_c.status, got.status);
                    errors++;
                end
                if (got.cx !== exp_c.cx) begin
                    $display("%0t: x expected %h actual %h", $time, exp_c.cx, got.cx);
                    errors++;
                end
                if (got.cy !== exp_c.cy) begin
                    $display("%0t: y expected %h actual %h", $time, exp_c.cy, got.cy);
                    errors++;
                end
                if (got.cz !== exp_c.cz) begin
                    $display("%0t: z expected %h actual %h", $time, exp_c.cz, got.cz);
                    errors++;
                end
            end
        end
        if (cycles == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // long receiver hold-off, counted here while the sender keeps offering items
    task automatic long_stall();
        hold_long = 1'b1;
        repeat (150) @(posedge aclk);
        hold_long = 1'b0;
    endtask

    typedef struct {
        query_t    q;
        bit        known;
        crossing_t c;
    } vector_t;

    vector_t directed[$];

    task automatic add_row(logic [FW-1:0] a, logic [FW-1:0] n,
                           logic [FW-1:0] x, logic [FW-1:0] y,
                           bit sb, bit eb, bit known, lpi_pkg::status_t st,
                           longint rx, longint ry, longint rz);
        vector_t v;
        v.q = '{a, n, x, y, sb, eb};
        v.known = known;
        v.c = '{st, rx[CW-1:0], ry[CW-1:0], rz[CW-1:0]};
        directed.push_back(v);
    endtask

    localparam longint ONE = 1024;
    localparam longint CMAX = (1 << 20) - 1;
    localparam longint CMIN = -(1 << 20);

    initial begin
        logic [FW-1:0] all1;
        logic [TW-1:0] tv[4];
        all1 = '1;
        // plane z=0, normal +z, line from z=-1 to z=+1 at x=y=1: crosses at midpoint
        add_row(vec3(0,0,0), vec3(0,0,ONE), vec3(ONE,ONE,-ONE), vec3(ONE,ONE,ONE),
                1, 1, 1, lpi_pkg::ST_ONE, ONE, ONE, 0);
        // parallel line off the plane
        add_row(vec3(0,0,0), vec3(0,0,ONE), vec3(0,0,ONE), vec3(ONE,0,ONE),
                0, 0, 1, lpi_pkg::ST_PARALLEL, 0, 0, 0);
        // line lying in the plane
        add_row(vec3(0,0,0), vec3(0,0,ONE), vec3(5,-7,0), vec3(ONE,0,0),
                1, 1, 1, lpi_pkg::ST_PLANE, 5, -7, 0);
        // crossing beyond the end, bounded and unbounded
        add_row(vec3(0,0,3*ONE), vec3(0,0,ONE), vec3(0,0,0), vec3(0,0,ONE),
                0, 1, 1, lpi_pkg::ST_OUTSIDE, 0, 0, 3*ONE);
        add_row(vec3(0,0,3*ONE), vec3(0,0,ONE), vec3(0,0,0), vec3(0,0,ONE),
                1, 0, 1, lpi_pkg::ST_ONE, 0, 0, 3*ONE);
        // crossing before the start
        add_row(vec3(0,0,-2*ONE), vec3(0,0,ONE), vec3(0,0,0), vec3(0,0,ONE),
                1, 0, 1, lpi_pkg::ST_OUTSIDE, 0, 0, -2*ONE);
        add_row(vec3(0,0,-2*ONE), vec3(0,0,ONE), vec3(0,0,0), vec3(0,0,ONE),
                0, 1, 1, lpi_pkg::ST_ONE, 0, 0, -2*ONE);
        // exactly at the end points
        add_row(vec3(0,0,0), vec3(0,0,ONE), vec3(0,0,0), vec3(0,0,ONE),
                1, 1, 1, lpi_pkg::ST_ONE, 0, 0, 0);
        add_row(vec3(0,0,ONE), vec3(0,0,ONE), vec3(0,0,0), vec3(0,0,ONE),
                1, 1, 1, lpi_pkg::ST_ONE, 0, 0, ONE);
        // huge quotient: tiny e, large d, saturates per component sign
        add_row(vec3(0,0,CMAX), vec3(0,0,CMAX), vec3(0,0,CMIN), vec3(1,-1,CMIN+1),
                0, 0, 0, lpi_pkg::ST_ONE, 0, 0, 0);
        // coordinate extremes
        add_row(vec3(CMAX,CMAX,CMAX), vec3(CMIN,CMIN,CMIN), vec3(CMIN,CMIN,CMIN),
                vec3(CMAX,CMAX,CMAX), 1, 1, 0, lpi_pkg::ST_ONE, 0, 0, 0);
        add_row(vec3(CMIN,CMAX,CMIN), vec3(CMAX,CMIN,CMAX), vec3(CMAX,CMIN,CMAX),
                vec3(CMIN,CMAX,CMIN), 0, 1, 0, lpi_pkg::ST_ONE, 0, 0, 0);
        add_row(all1, all1, all1, all1, 1, 1, 0, lpi_pkg::ST_ONE, 0, 0, 0);
        add_row('0, '0, '0, '0, 0, 0, 1, lpi_pkg::ST_PLANE, 0, 0, 0);
        add_row(all1, '0, all1, '0, 1, 0, 0, lpi_pkg::ST_ONE, 0, 0, 0);
        add_row('0, all1, '0, all1, 0, 1, 0, lpi_pkg::ST_ONE, 0, 0, 0);
        // negative direction and a tiny normal with offset
        add_row(vec3(0,0,0), vec3(ONE,ONE,ONE), vec3(ONE,2*ONE,3*ONE),
                vec3(-ONE,-3*ONE,5*ONE), 1, 1, 0, lpi_pkg::ST_ONE, 0, 0, 0);
        add_row(vec3(ONE,0,0), vec3(3,0,0), vec3(0,0,0), vec3(0,ONE,0),
                0, 0, 0, lpi_pkg::ST_ONE, 0, 0, 0);

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) begin
            if (directed[i].known && predict_crossing(directed[i].q) !== directed[i].c) begin
                $display("%0t: table row %0d expected %h predicted %h", $time, i,
                         directed[i].c, predict_crossing(directed[i].q));
                errors++;
            end
            send_query(directed[i].q);
        end

        // tolerance sweep: zero, maximum, 64 and the reset value, then random settings
        tv = '{20'd0, 20'hFFFFF, 20'd64, lpi_pkg::TOL_RESET};
        foreach (tv[j]) begin
            write_tolerance(tv[j]);
            for (int n = 0; n < 60; n++) send_query(rand_query());
        end

        write_tolerance(TW'($urandom_range(2000, 0)));
        fork
            long_stall();
            for (int n = 0; n < 100; n++) send_query(rand_query());
        join
        // wait out every result before going on
        drain();
        write_tolerance(TW'($urandom));
        for (int n = 0; n < 60; n++) send_query(rand_query());
        write_tolerance(lpi_pkg::TOL_RESET);
        quiet = 1'b1;
        for (int n = 0; n < 70; n++) send_query(rand_query());
        s_tvalid <= 1'b0;

        while (pending_crossings.size() != 0) @(posedge aclk);
        repeat (LAT + 10) @(posedge aclk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
